// ===== src/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Shared constants, request and response types, page word layout and helpers.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int NUM_PAGES  = 16384;
  localparam int NUM_ORDERS = 20;
  localparam int PAGE_W     = 14;
  localparam int LINK_W     = 15;
  localparam int ORD_W      = 5;
  localparam int CNT_W      = 15;
  localparam int TOT_W      = 35;

  localparam logic [LINK_W-1:0] LIST_NIL = LINK_W'(NUM_PAGES);
  localparam logic [ORD_W-1:0]  ORD_TOP  = ORD_W'(NUM_ORDERS - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_ALLOC = 2'd1,
    MODE_FREE  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BADREQ  = 2'd2,
    ST_RSVD    = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [PAGE_W-1:0] page_index;
    logic [CNT_W-1:0]  page_count;
  } in_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PAGE_W-1:0] block_index;
    logic [CNT_W-1:0]  free_total;
  } out_rsp_t;

  typedef struct packed {
    logic              free;
    logic [ORD_W-1:0]  ord;
    logic [LINK_W-1:0] nxt;
    logic [LINK_W-1:0] prv;
  } page_word_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DEC, S_ADD, S_ADD_NXT, S_SRCH, S_SPLIT,
    S_FRD, S_FCHK, S_MRG, S_MCHK, S_MSTEP,
    S_PUSH, S_PH_RD, S_PH_WR,
    S_RM_RD, S_RM_CAP, S_RP_RD, S_RP_WR, S_RN_RD, S_RN_WR, S_RF_RD, S_RF_WR,
    S_DONE
  } state_t;

  // Smallest order whose block holds cnt pages, capped at the top order.
  function automatic logic [ORD_W-1:0] order_for(input logic [CNT_W-1:0] cnt);
    logic [ORD_W-1:0] o;
    o = '0;
    for (int i = 0; i < NUM_ORDERS - 1; i++) begin
      if ((32'(1) << i) < 32'(cnt)) o = ORD_W'(i + 1);
    end
    return o;
  endfunction

  // Largest order aligned to pos that fits in rem, capped at the top order.
  function automatic logic [ORD_W-1:0] region_order(input logic [LINK_W-1:0] pos,
                                                    input logic [CNT_W-1:0] rem);
    logic [ORD_W-1:0] o;
    logic             ok;
    o  = '0;
    ok = 1'b1;
    for (int i = 0; i < NUM_ORDERS - 1; i++) begin
      ok = ok && ((32'(pos) & ((32'(2) << i) - 32'(1))) == 32'(0)) &&
           ((32'(2) << i) <= 32'(rem));
      if (ok) o = ORD_W'(i + 1);
    end
    return o;
  endfunction

endpackage

// ===== src/bpa_page_ram.sv =====
// ----------------------------------------------------------------------------
// Page word memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bpa_page_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [bpa_pkg::PAGE_W-1:0] waddr,
  input  bpa_pkg::page_word_t        wdata,
  input  logic [bpa_pkg::PAGE_W-1:0] raddr,
  output bpa_pkg::page_word_t        rdata
);
  import bpa_pkg::*;

  page_word_t mem [NUM_PAGES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/buddy_page_allocator.sv =====
// ----------------------------------------------------------------------------
// Buddy page allocator
// Free lists per order over a page word memory, driven by a sequencer.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. It carries a mode
// (add region, allocate, free), a first page and a page count. Exactly one
// response follows: out_valid is high for one cycle with status, the first
// page of an allocated block and the total of free pages.
// List updates read, modify and write each neighbour entry in the page word
// memory; busy stays high through the response cycle. A push writes the new
// entry and, unless its list was empty, reads and rewrites the old head; a
// removal reads the entry, relinks its neighbours where present and rewrites
// it as not free. Allocation searches one order per cycle and splits one
// order per step; freeing merges one order per step. A rejected request
// passes only through S_DEC before its response in S_DONE.
// After reset the page memory is swept clear, one entry per cycle, and the
// block stays busy until the sweep ends; only then is a request taken.
// The receiver cannot stall: the response is shown for one cycle only.
// ----------------------------------------------------------------------------
module buddy_page_allocator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bpa_pkg::in_req_t  in_req,
  output logic              out_valid,
  output bpa_pkg::out_rsp_t out_rsp
);
  import bpa_pkg::*;

  state_t            state_r, state_nxt, ret_r, ret_nxt;
  logic [PAGE_W-1:0] clr_r, clr_nxt;
  in_req_t           req_r, req_nxt;
  logic [LINK_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [ORD_W-1:0]  cur_r, cur_nxt, want_r, want_nxt;
  logic [LINK_W-1:0] pg_r, pg_nxt, b_r, b_nxt, h_r, h_nxt, n_r, n_nxt, p_r, p_nxt;
  logic [PAGE_W-1:0] base_r, base_nxt;
  logic [ORD_W-1:0]  ps_ord_r, ps_ord_nxt, rm_ord_r, rm_ord_nxt;
  logic [LINK_W-1:0] ps_pg_r, ps_pg_nxt, rm_pg_r, rm_pg_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [PAGE_W-1:0] blk_r, blk_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic [LINK_W-1:0] head_r [NUM_ORDERS];
  logic [LINK_W-1:0] head_nxt [NUM_ORDERS];
  logic [CNT_W-1:0]  count_r [NUM_ORDERS];
  logic [CNT_W-1:0]  count_nxt [NUM_ORDERS];

  logic [ORD_W-1:0]  ord_sel;
  logic [LINK_W-1:0] head_sel;
  logic [CNT_W-1:0]  count_sel;
  logic [TOT_W-1:0]  ord_unit;

  logic              mem_we;
  logic [PAGE_W-1:0] mem_waddr, mem_raddr;
  page_word_t        mem_wdata, mem_rdata;

  bpa_page_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    case (state_r)
      S_PUSH:                        ord_sel = ps_ord_r;
      S_RM_CAP, S_RF_WR:             ord_sel = rm_ord_r;
      default:                       ord_sel = cur_r;
    endcase
  end

  assign head_sel  = (32'(ord_sel) < NUM_ORDERS) ? head_r[ord_sel] : LIST_NIL;
  assign count_sel = (32'(ord_sel) < NUM_ORDERS) ? count_r[ord_sel] : '0;
  assign ord_unit  = TOT_W'(1) << ord_sel;

  always_comb begin
    logic [31:0]      t;
    logic [ORD_W-1:0] o;
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    clr_nxt    = clr_r;
    req_nxt    = req_r;
    pos_nxt    = pos_r;
    rem_nxt    = rem_r;
    cur_nxt    = cur_r;
    want_nxt   = want_r;
    pg_nxt     = pg_r;
    b_nxt      = b_r;
    h_nxt      = h_r;
    n_nxt      = n_r;
    p_nxt      = p_r;
    base_nxt   = base_r;
    ps_ord_nxt = ps_ord_r;
    ps_pg_nxt  = ps_pg_r;
    rm_ord_nxt = rm_ord_r;
    rm_pg_nxt  = rm_pg_r;
    status_nxt = status_r;
    blk_nxt    = blk_r;
    total_nxt  = total_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    t          = '0;
    o          = '0;
    case (state_r)
      S_CLR: begin
        clr_nxt = clr_r + PAGE_W'(1);
        if (clr_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          req_nxt    = in_req;
          status_nxt = ST_DONE;
          blk_nxt    = '0;
          state_nxt  = S_DEC;
        end
      end
      S_DEC: begin
        case (req_r.mode)
          MODE_ADD: begin
            if (req_r.page_count == '0 ||
                32'(req_r.page_index) + 32'(req_r.page_count) > NUM_PAGES) begin
              status_nxt = ST_BADREQ;
              state_nxt  = S_DONE;
            end else begin
              pos_nxt   = LINK_W'(req_r.page_index);
              rem_nxt   = req_r.page_count;
              state_nxt = S_ADD;
            end
          end
          MODE_ALLOC: begin
            if (req_r.page_count == '0 || 32'(req_r.page_count) > NUM_PAGES) begin
              status_nxt = ST_BADREQ;
              state_nxt  = S_DONE;
            end else begin
              want_nxt  = order_for(req_r.page_count);
              cur_nxt   = order_for(req_r.page_count);
              state_nxt = S_SRCH;
            end
          end
          MODE_FREE: begin
            o = order_for(req_r.page_count);
            if (req_r.page_count == '0 || 32'(req_r.page_count) > NUM_PAGES ||
                32'(req_r.page_index) + (32'(1) << o) > NUM_PAGES) begin
              status_nxt = ST_BADREQ;
              state_nxt  = S_DONE;
            end else begin
              cur_nxt   = o;
              base_nxt  = req_r.page_index;
              state_nxt = S_FRD;
            end
          end
          default: begin
            status_nxt = ST_BADREQ;
            state_nxt  = S_DONE;
          end
        endcase
      end
      S_ADD: begin
        o          = region_order(pos_r, rem_r);
        cur_nxt    = o;
        ps_ord_nxt = o;
        ps_pg_nxt  = pos_r;
        ret_nxt    = S_ADD_NXT;
        state_nxt  = S_PUSH;
      end
      S_ADD_NXT: begin
        pos_nxt = pos_r + LINK_W'(32'(1) << cur_r);
        rem_nxt = rem_r - CNT_W'(32'(1) << cur_r);
        state_nxt = (rem_nxt == '0) ? S_DONE : S_ADD;
      end
      S_SRCH: begin
        if (head_sel != LIST_NIL && !head_sel[LINK_W-1]) begin
          pg_nxt     = head_sel;
          rm_ord_nxt = cur_r;
          rm_pg_nxt  = head_sel;
          ret_nxt    = S_SPLIT;
          state_nxt  = S_RM_RD;
        end else if (cur_r >= ORD_TOP) begin
          status_nxt = ST_NOSPACE;
          state_nxt  = S_DONE;
        end else begin
          cur_nxt = cur_r + ORD_W'(1);
        end
      end
      S_SPLIT: begin
        if (cur_r > want_r) begin
          o       = cur_r - ORD_W'(1);
          cur_nxt = o;
          t       = 32'(pg_r) + (32'(1) << o);
          if (t < NUM_PAGES) begin
            ps_ord_nxt = o;
            ps_pg_nxt  = LINK_W'(t);
            ret_nxt    = S_SPLIT;
            state_nxt  = S_PUSH;
          end
        end else begin
          blk_nxt   = pg_r[PAGE_W-1:0];
          state_nxt = S_DONE;
        end
      end
      S_FRD: state_nxt = S_FCHK;
      S_FCHK: state_nxt = mem_rdata.free ? S_DONE : S_MRG;
      S_MRG: begin
        t = 32'(base_r) ^ (32'(1) << cur_r);
        if (cur_r < ORD_TOP && t < NUM_PAGES) begin
          b_nxt     = LINK_W'(t);
          state_nxt = S_MCHK;
        end else begin
          ps_ord_nxt = cur_r;
          ps_pg_nxt  = LINK_W'(base_r);
          ret_nxt    = S_DONE;
          state_nxt  = S_PUSH;
        end
      end
      S_MCHK: begin
        if (mem_rdata.free && mem_rdata.ord == cur_r) begin
          rm_ord_nxt = cur_r;
          rm_pg_nxt  = b_r;
          ret_nxt    = S_MSTEP;
          state_nxt  = S_RM_RD;
        end else begin
          ps_ord_nxt = cur_r;
          ps_pg_nxt  = LINK_W'(base_r);
          ret_nxt    = S_DONE;
          state_nxt  = S_PUSH;
        end
      end
      S_MSTEP: begin
        if (b_r < LINK_W'(base_r)) base_nxt = b_r[PAGE_W-1:0];
        cur_nxt   = cur_r + ORD_W'(1);
        state_nxt = S_MRG;
      end
      S_PUSH: begin
        h_nxt              = head_sel;
        head_nxt[ord_sel]  = ps_pg_r;
        count_nxt[ord_sel] = count_sel + CNT_W'(1);
        if (count_sel == CNT_MAX) begin
          total_nxt = total_r + ord_unit - (ord_unit << CNT_W);
        end else begin
          total_nxt = total_r + ord_unit;
        end
        state_nxt = head_sel[LINK_W-1] ? ret_r : S_PH_RD;
      end
      S_PH_RD: state_nxt = S_PH_WR;
      S_PH_WR: state_nxt = ret_r;
      S_RM_RD: state_nxt = S_RM_CAP;
      S_RM_CAP: begin
        n_nxt = mem_rdata.nxt;
        p_nxt = mem_rdata.prv;
        if (mem_rdata.prv[LINK_W-1]) begin
          head_nxt[ord_sel] = mem_rdata.nxt;
          state_nxt = mem_rdata.nxt[LINK_W-1] ? S_RF_RD : S_RN_RD;
        end else begin
          state_nxt = S_RP_RD;
        end
      end
      S_RP_RD: state_nxt = S_RP_WR;
      S_RP_WR: state_nxt = n_r[LINK_W-1] ? S_RF_RD : S_RN_RD;
      S_RN_RD: state_nxt = S_RN_WR;
      S_RN_WR: state_nxt = S_RF_RD;
      S_RF_RD: state_nxt = S_RF_WR;
      S_RF_WR: begin
        count_nxt[ord_sel] = count_sel - CNT_W'(1);
        if (count_sel == '0) begin
          total_nxt = total_r + (ord_unit << CNT_W) - ord_unit;
        end else begin
          total_nxt = total_r - ord_unit;
        end
        state_nxt = ret_r;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
      end
      S_FRD:   mem_raddr = req_r.page_index;
      S_MRG:   mem_raddr = PAGE_W'(32'(base_r) ^ (32'(1) << cur_r));
      S_PUSH: begin
        mem_we         = 1'b1;
        mem_waddr      = ps_pg_r[PAGE_W-1:0];
        mem_wdata.free = 1'b1;
        mem_wdata.ord  = ps_ord_r;
        mem_wdata.nxt  = head_sel;
        mem_wdata.prv  = LIST_NIL;
      end
      S_PH_RD: mem_raddr = h_r[PAGE_W-1:0];
      S_PH_WR: begin
        mem_we        = 1'b1;
        mem_waddr     = h_r[PAGE_W-1:0];
        mem_wdata     = mem_rdata;
        mem_wdata.prv = ps_pg_r;
      end
      S_RM_RD: mem_raddr = rm_pg_r[PAGE_W-1:0];
      S_RP_RD: mem_raddr = p_r[PAGE_W-1:0];
      S_RP_WR: begin
        mem_we        = 1'b1;
        mem_waddr     = p_r[PAGE_W-1:0];
        mem_wdata     = mem_rdata;
        mem_wdata.nxt = n_r;
      end
      S_RN_RD: mem_raddr = n_r[PAGE_W-1:0];
      S_RN_WR: begin
        mem_we        = 1'b1;
        mem_waddr     = n_r[PAGE_W-1:0];
        mem_wdata     = mem_rdata;
        mem_wdata.prv = p_r;
      end
      S_RF_RD: mem_raddr = rm_pg_r[PAGE_W-1:0];
      S_RF_WR: begin
        mem_we         = 1'b1;
        mem_waddr      = rm_pg_r[PAGE_W-1:0];
        mem_wdata      = mem_rdata;
        mem_wdata.free = 1'b0;
      end
      default: mem_we = 1'b0;
    endcase
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = (state_r == S_DONE);
  assign out_rsp.status      = status_r;
  assign out_rsp.block_index = blk_r;
  assign out_rsp.free_total  = (total_r > TOT_W'(CNT_MAX)) ? CNT_MAX : total_r[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      total_r <= '0;
      for (int i = 0; i < NUM_ORDERS; i++) begin
        head_r[i]  <= LIST_NIL;
        count_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      total_r <= total_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r    <= ret_nxt;
    req_r    <= req_nxt;
    pos_r    <= pos_nxt;
    rem_r    <= rem_nxt;
    cur_r    <= cur_nxt;
    want_r   <= want_nxt;
    pg_r     <= pg_nxt;
    b_r      <= b_nxt;
    h_r      <= h_nxt;
    n_r      <= n_nxt;
    p_r      <= p_nxt;
    base_r   <= base_nxt;
    ps_ord_r <= ps_ord_nxt;
    ps_pg_r  <= ps_pg_nxt;
    rm_ord_r <= rm_ord_nxt;
    rm_pg_r  <= rm_pg_nxt;
    status_r <= status_nxt;
    blk_r    <= blk_nxt;
  end

endmodule

// ===== src/bpa_checker.sv =====
// ----------------------------------------------------------------------------
// Buddy page allocator checker
// Port level properties of the request and response sequence.
// ----------------------------------------------------------------------------
module bpa_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input bpa_pkg::in_req_t  in_req,
  input logic              out_valid,
  input bpa_pkg::out_rsp_t out_rsp
);
  import bpa_pkg::*;

  logic unused_req;
  assign unused_req = ^in_req;

  a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("Accepted request did not raise busy.");

  a_rsp_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("Response shown while idle.");

  a_rsp_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy && !out_valid)
    else $error("Response not followed by an idle cycle.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rsp.status != ST_RSVD)
    else $error("Reserved status code.");

  a_block_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.status != ST_DONE |-> out_rsp.block_index == '0)
    else $error("Block index set on a failed request.");

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// Buddy page allocator testbench
// Drives add, allocate, free and invalid mode requests with random gaps, predicts every
// response with a behavioral buddy allocator and compares each response.
// ----------------------------------------------------------------------------
module tb_top;
  import bpa_pkg::*;

  localparam int WATCHDOG_LIMIT = 100000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_req_t   in_req;
  logic      out_valid;
  out_rsp_t  out_rsp;

  buddy_page_allocator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_rsp(out_rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bit          page_free[NUM_PAGES];
  int unsigned page_ord[NUM_PAGES];
  int unsigned next_link[NUM_PAGES];
  int unsigned prev_link[NUM_PAGES];
  int unsigned list_head[NUM_ORDERS];
  int unsigned list_count[NUM_ORDERS];

  out_rsp_t    pending_rsp[$];
  int          mismatches;
  int          idle_cycles;
  int          send_gap_pct;

  function automatic void push_block(int unsigned o, int unsigned pg);
    int unsigned h;
    h = list_head[o];
    next_link[pg] = h;
    prev_link[pg] = NUM_PAGES;
    if (h < NUM_PAGES) prev_link[h] = pg;
    list_head[o] = pg;
    list_count[o] = (list_count[o] + 1) & 32'h7fff;
    page_free[pg] = 1'b1;
    page_ord[pg] = o & 5'h1f;
  endfunction

  function automatic void remove_block(int unsigned o, int unsigned pg);
    int unsigned n, p;
    n = next_link[pg];
    p = prev_link[pg];
    if (p >= NUM_PAGES) list_head[o] = n;
    else next_link[p] = n;
    if (n < NUM_PAGES) prev_link[n] = p;
    list_count[o] = (list_count[o] - 1) & 32'h7fff;
    page_free[pg] = 1'b0;
  endfunction

  function automatic int unsigned fit_order(int unsigned cnt);
    int unsigned o;
    o = 0;
    while (o < NUM_ORDERS - 1 && (1 << o) < cnt) o++;
    return o;
  endfunction

  function automatic out_rsp_t predict_allocator(in_req_t r);
    out_rsp_t    rsp;
    int unsigned idx, cnt, pos, rem, o, cur, want, pg, base, b;
    longint unsigned total;
    status_t     st;
    st = ST_DONE;
    idx = r.page_index;
    cnt = r.page_count;
    pg = 0;
    case (mode_t'(r.mode))
      MODE_ADD: begin
        if (cnt == 0 || idx + cnt > NUM_PAGES) st = ST_BADREQ;
        else begin
          pos = idx;
          rem = cnt;
          while (rem > 0) begin
            o = 0;
            while (o < NUM_ORDERS - 1 && (pos & ((2 << o) - 1)) == 0 && (2 << o) <= rem)
              o++;
            push_block(o, pos);
            pos += 1 << o;
            rem -= 1 << o;
          end
        end
      end
      MODE_ALLOC: begin
        if (cnt == 0 || cnt > (1 << (NUM_ORDERS - 1)) || cnt > NUM_PAGES) st = ST_BADREQ;
        else begin
          want = fit_order(cnt);
          cur = want;
          while (cur < NUM_ORDERS && list_head[cur] >= NUM_PAGES) cur++;
          if (cur >= NUM_ORDERS) st = ST_NOSPACE;
          else begin
            pg = list_head[cur];
            remove_block(cur, pg);
            while (cur > want) begin
              cur--;
              if (pg + (1 << cur) < NUM_PAGES) push_block(cur, pg + (1 << cur));
            end
          end
        end
      end
      MODE_FREE: begin
        o = fit_order(cnt);
        if (cnt == 0 || cnt > (1 << (NUM_ORDERS - 1)) || cnt > NUM_PAGES ||
            idx + (1 << o) > NUM_PAGES) st = ST_BADREQ;
        else if (!page_free[idx]) begin
          base = idx;
          while (o < NUM_ORDERS - 1) begin
            b = base ^ (1 << o);
            if (b < NUM_PAGES && page_free[b] && page_ord[b] == o) begin
              remove_block(o, b);
              if (b < base) base = b;
              o++;
            end else break;
          end
          push_block(o, base);
        end
      end
      default: st = ST_BADREQ;
    endcase
    total = 0;
    for (int i = 0; i < NUM_ORDERS; i++) total += longint'(list_count[i]) << i;
    if (total > 32767) total = 32767;
    rsp.status = st;
    rsp.block_index = pg[PAGE_W-1:0];
    rsp.free_total = total[CNT_W-1:0];
    return rsp;
  endfunction

  // Allocated blocks the stimulus may hand back, as first page and size.
  int unsigned held_page[$];
  int unsigned held_size[$];

  task automatic send_request(mode_t m, int unsigned idx, int unsigned cnt);
    in_req_t r;
    out_rsp_t p;
    while ($urandom_range(99) < send_gap_pct) @(posedge clk);
    r.mode = m;
    r.page_index = idx[PAGE_W-1:0];
    r.page_count = cnt[CNT_W-1:0];
    start <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    p = predict_allocator(r);
    pending_rsp.push_back(p);
    if (m == MODE_ALLOC && p.status == ST_DONE) begin
      held_page.push_back(p.block_index);
      held_size.push_back(1 << fit_order(cnt));
    end
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic free_held(int k);
    send_request(MODE_FREE, held_page[k], held_size[k]);
    held_page.delete(k);
    held_size.delete(k);
  endtask

  task automatic test_directed();
    send_request(MODE_ALLOC, 0, 1);
    send_request(MODE_ADD, 0, 0);
    send_request(MODE_ADD, 16383, 2);
    send_request(MODE_ADD, 3, 13);
    send_request(MODE_ALLOC, 0, 0);
    send_request(MODE_ALLOC, 0, 16384);
    send_request(MODE_ALLOC, 0, 32767);
    send_request(MODE_ALLOC, 16383, 1);
    send_request(MODE_ALLOC, 0, 3);
    send_request(MODE_ALLOC, 0, 8);
    send_request(MODE_FREE, 0, 0);
    send_request(MODE_FREE, 16383, 2);
    send_request(MODE_FREE, 0, 32767);
    send_request(MODE_NONE, 16383, 32767);
    while (held_page.size() != 0) free_held(0);
    send_request(MODE_FREE, 3, 1);
    send_request(MODE_ADD, 16, 16368);
    send_request(MODE_ALLOC, 0, 16384);
    send_request(MODE_ALLOC, 0, 8192);
    while (held_page.size() != 0) free_held(0);
    wait_drained();
  endtask

  task automatic test_random(int n);
    int unsigned sel, cnt;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      cnt = ($urandom_range(9) == 0) ? $urandom_range(16384) :
            $urandom_range(1, 1 << $urandom_range(6));
      if (sel < 45) send_request(MODE_ALLOC, $urandom, cnt);
      else if (sel < 85 && held_page.size() != 0)
        free_held($urandom_range(held_page.size() - 1));
      else if (sel < 88) send_request(MODE_NONE, $urandom, $urandom);
      else if (sel < 92) send_request(MODE_ALLOC, $urandom, $urandom);
      else if (sel < 96) send_request(MODE_ADD, 16383 - $urandom_range(3), $urandom);
      else send_request(MODE_FREE, $urandom, $urandom_range(1) ? 0 : 32768 - $urandom_range(9));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %h", out_rsp);
      end else begin
        if (out_rsp.status !== pending_rsp[0].status ||
            out_rsp.block_index !== pending_rsp[0].block_index ||
            out_rsp.free_total !== pending_rsp[0].free_total) begin
          mismatches++;
          if (mismatches <= 10)
            $display("response mismatch: expected %h actual %h", pending_rsp[0], out_rsp);
        end
        void'(pending_rsp.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_n && idle_cycles > WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    mismatches = 0;
    idle_cycles = 0;
    send_gap_pct = 11;
    for (int o = 0; o < NUM_ORDERS; o++) begin
      list_head[o] = NUM_PAGES;
      list_count[o] = 0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    test_directed();
    test_random(500);
    wait_drained();
    send_gap_pct = 68;
    test_random(500);
    send_gap_pct = 0;
    test_random(500);
    wait_drained();
    repeat (400) @(posedge clk);
    if (mismatches == 0 && pending_rsp.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

// ===== filelist.f =====
src/bpa_pkg.sv
src/bpa_page_ram.sv
src/buddy_page_allocator.sv
src/bpa_checker.sv
test/tb_top.sv
